/* design/hrp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// hrp_pkg
// shared types, character codes and method table for the request parser
// ============================================================================
package hrp_pkg;

    // results one input byte can produce
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // default depth of the run queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_SP     = 8'h20;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam int NUM_VERBS = 9;
    localparam int VERB_MAX  = 7;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_URL     = 4'd1,
        PH_VERSION = 4'd2,
        PH_REQREST = 4'd3,
        PH_NAME    = 4'd4,
        PH_VALUE   = 4'd5,
        PH_SKIP    = 4'd6,
        PH_STOP    = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_URL     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_NAME    = 3'd3,
        KIND_VALUE   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_METHOD  = 3'd1,
        ST_NO_URL      = 3'd2,
        ST_NO_VERSION  = 3'd3,
        ST_EMPTY_NAME  = 3'd4,
        ST_BAD_NAME    = 3'd5
    } status_t;

    // one result item, less the end-of-run flag which the back part derives
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        kind_t      field_kind;
        logic       token_end;
        status_t    status;
        logic       headers_done;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        logic [RES_CNT_W-1:0]   cnt;
    } run_t;

    // known methods, lowercase, zero padded
    localparam logic [7:0] VERB_CHARS [NUM_VERBS][VERB_MAX+1] = '{
        '{"g", "e", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"p", "o", "s", "t", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"o", "p", "t", "i", "o", "n", "s", 8'h0},
        '{"p", "u", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"d", "e", "l", "e", "t", "e", 8'h0, 8'h0},
        '{"t", "r", "a", "c", "e", 8'h0, 8'h0, 8'h0},
        '{"c", "o", "n", "n", "e", "c", "t", 8'h0},
        '{"p", "a", "t", "c", "h", 8'h0, 8'h0, 8'h0},
        '{"h", "e", "a", "d", 8'h0, 8'h0, 8'h0, 8'h0}
    };

    localparam logic [2:0] VERB_LEN [NUM_VERBS] = '{
        3'd3, 3'd4, 3'd7, 3'd3, 3'd6, 3'd5, 3'd7, 3'd5, 3'd4
    };

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

endpackage

/* design/http_request_header_parser.sv */
`timescale 1ns / 1ps
// ============================================================================
// http_request_header_parser
// streaming request header parser: bytes in, tagged field bytes and token
// ends out
// ============================================================================
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ----------------------------------
// in       sink       in_valid / in_stall  data_byte, last_byte
// out      source     out_valid / out_stall out_byte, byte_valid, field_kind,
//                                          token_end, status, headers_done,
//                                          last_of_run
//
// one byte is taken per cycle while in_stall is low; the front part runs the
// whole parse step for that byte in the same cycle and queues its run of one
// to three results; the back part sends one result per cycle while out_stall
// is low, so a byte that causes k results holds the output until all k are
// sent; the run queue absorbs these bursts and in_stall rises only when it is full
// a byte with no result (held cr or colon, ignored tail) never reaches the
// queue; reset empties the queue and returns the parse to the method field
//
// front: lowercasing, method match against nine candidates, name check,
// delimiter confirmation with one held byte, line and phase tracking
// back:  walks the head run and flags its final result with last_of_run
// ============================================================================
module http_request_header_parser
#(
    parameter int QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    // result item channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] field_kind,
    output logic       token_end,
    output logic [2:0] status,
    output logic       headers_done,
    output logic       last_of_run
);

    // front to queue
    logic          push;
    hrp_pkg::run_t push_run;
    logic          queue_full;

    // queue to back
    logic          head_valid;
    hrp_pkg::run_t head_run;
    logic          pop;

    // parse step per accepted byte
    hrp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .in_stall   (in_stall),
        .push       (push),
        .push_run   (push_run)
    );

    // decouples the parse from output back pressure
    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    // serializes each run onto the output channel
    hrp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_run     (head_run),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .field_kind   (field_kind),
        .token_end    (token_end),
        .status       (status),
        .headers_done (headers_done),
        .last_of_run  (last_of_run)
    );

endmodule

/* design/hrp_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// hrp_front
// accepts one byte per cycle unless the queue is full, tracks the parse and builds its run of results
// ============================================================================
module hrp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                queue_full,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                in_stall,
    output logic                push,
    output hrp_pkg::run_t       push_run
);

    typedef struct packed {
        hrp_pkg::phase_t              phase;
        logic [7:0]                   held_char;
        logic                         held_flag;
        logic [hrp_pkg::NUM_VERBS-1:0] cand;
        logic [2:0]                   pos;
        logic                         name_good;
        logic                         name_nonempty;
        logic                         line_empty;
    } pstate_t;

    typedef struct packed {
        pstate_t       s;
        hrp_pkg::run_t run;
    } ctx_t;

    pstate_t state_reg;
    pstate_t state_next;
    ctx_t    ctx;
    logic    accept;

    function automatic ctx_t emit(input ctx_t x, input logic [7:0] b, input logic v,
                                  input hrp_pkg::kind_t k, input logic te,
                                  input hrp_pkg::status_t st, input logic hd);
        hrp_pkg::res_t r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.field_kind   = k;
        r.token_end    = te;
        r.status       = st;
        r.headers_done = hd;
        if (x.run.cnt < hrp_pkg::RES_CNT_W'(hrp_pkg::MAX_RESULTS))
        begin
            x.run.res[x.run.cnt] = r;
            x.run.cnt = x.run.cnt + hrp_pkg::RES_CNT_W'(1);
        end
        return x;
    endfunction

    function automatic logic verb_known(input pstate_t s);
        logic k;
        k = 1'b0;
        for (int m = 0; m < hrp_pkg::NUM_VERBS; m++)
        begin
            if (s.cand[m] && hrp_pkg::VERB_LEN[m] == s.pos)
            begin
                k = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic pstate_t new_line(input pstate_t s);
        s.phase         = hrp_pkg::PH_NAME;
        s.name_good     = 1'b1;
        s.name_nonempty = 1'b0;
        s.line_empty    = 1'b1;
        return s;
    endfunction

    function automatic ctx_t field_byte(input ctx_t x, input logic [7:0] c);
        logic [7:0] l;
        logic       keep;
        l = hrp_pkg::to_lower(c);
        x.s.line_empty = 1'b0;
        case (x.s.phase)
            hrp_pkg::PH_METHOD:
            begin
                for (int m = 0; m < hrp_pkg::NUM_VERBS; m++)
                begin
                    keep = x.s.pos < 3'(hrp_pkg::VERB_MAX) && x.s.pos < hrp_pkg::VERB_LEN[m]
                           && hrp_pkg::VERB_CHARS[m][x.s.pos] == l;
                    if (!keep)
                    begin
                        x.s.cand[m] = 1'b0;
                    end
                end
                if (x.s.pos < 3'(hrp_pkg::VERB_MAX))
                begin
                    x.s.pos = x.s.pos + 3'd1;
                end
                x = emit(x, l, 1'b1, hrp_pkg::KIND_METHOD, 1'b0, hrp_pkg::ST_OK, 1'b0);
            end
            hrp_pkg::PH_URL:
            begin
                x = emit(x, c, 1'b1, hrp_pkg::KIND_URL, 1'b0, hrp_pkg::ST_OK, 1'b0);
            end
            hrp_pkg::PH_VERSION:
            begin
                x = emit(x, c, 1'b1, hrp_pkg::KIND_VERSION, 1'b0, hrp_pkg::ST_OK, 1'b0);
            end
            hrp_pkg::PH_NAME:
            begin
                if (!(l inside {[hrp_pkg::CHAR_LOWER_A:hrp_pkg::CHAR_LOWER_Z],
                                hrp_pkg::CHAR_HYPHEN}))
                begin
                    x.s.name_good = 1'b0;
                end
                x.s.name_nonempty = 1'b1;
                x = emit(x, l, 1'b1, hrp_pkg::KIND_NAME, 1'b0, hrp_pkg::ST_OK, 1'b0);
            end
            hrp_pkg::PH_VALUE:
            begin
                x = emit(x, c, 1'b1, hrp_pkg::KIND_VALUE, 1'b0, hrp_pkg::ST_OK, 1'b0);
            end
            default:
            begin
            end
        endcase
        return x;
    endfunction

    function automatic ctx_t release_held(input ctx_t x);
        if (x.s.held_flag)
        begin
            x.s.held_flag = 1'b0;
            x = field_byte(x, x.s.held_char);
            x.s.held_char = 8'h00;
        end
        return x;
    endfunction

    function automatic ctx_t space_delim(input ctx_t x);
        x.s.line_empty = 1'b0;
        case (x.s.phase)
            hrp_pkg::PH_METHOD:
            begin
                if (verb_known(x.s))
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_METHOD, 1'b1, hrp_pkg::ST_OK, 1'b0);
                    x.s.phase = hrp_pkg::PH_URL;
                end
                else
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_METHOD, 1'b1,
                             hrp_pkg::ST_BAD_METHOD, 1'b0);
                    x.s.phase = hrp_pkg::PH_STOP;
                end
            end
            hrp_pkg::PH_URL:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_URL, 1'b1, hrp_pkg::ST_OK, 1'b0);
                x.s.phase = hrp_pkg::PH_VERSION;
            end
            hrp_pkg::PH_VERSION:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_VERSION, 1'b1, hrp_pkg::ST_OK, 1'b0);
                x.s.phase = hrp_pkg::PH_REQREST;
            end
            default:
            begin
            end
        endcase
        return x;
    endfunction

    function automatic ctx_t colon_space(input ctx_t x);
        x.s.line_empty = 1'b0;
        case (x.s.phase)
            hrp_pkg::PH_NAME:
            begin
                if (!x.s.name_nonempty)
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_NAME, 1'b1,
                             hrp_pkg::ST_EMPTY_NAME, 1'b0);
                    x.s.phase = hrp_pkg::PH_SKIP;
                end
                else if (!x.s.name_good)
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_NAME, 1'b1,
                             hrp_pkg::ST_BAD_NAME, 1'b0);
                    x.s.phase = hrp_pkg::PH_SKIP;
                end
                else
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_NAME, 1'b1, hrp_pkg::ST_OK, 1'b0);
                    x.s.phase = hrp_pkg::PH_VALUE;
                end
            end
            hrp_pkg::PH_VALUE:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_VALUE, 1'b1, hrp_pkg::ST_OK, 1'b0);
                x.s.phase = hrp_pkg::PH_SKIP;
            end
            default:
            begin
            end
        endcase
        return x;
    endfunction

    function automatic ctx_t end_of_line(input ctx_t x);
        case (x.s.phase)
            hrp_pkg::PH_METHOD:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_METHOD, 1'b1,
                         verb_known(x.s) ? hrp_pkg::ST_NO_URL : hrp_pkg::ST_BAD_METHOD, 1'b0);
                x.s.phase = hrp_pkg::PH_STOP;
            end
            hrp_pkg::PH_URL:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_URL, 1'b1, hrp_pkg::ST_NO_VERSION, 1'b0);
                x.s.phase = hrp_pkg::PH_STOP;
            end
            hrp_pkg::PH_VERSION:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_VERSION, 1'b1, hrp_pkg::ST_OK, 1'b0);
                x.s = new_line(x.s);
            end
            hrp_pkg::PH_NAME:
            begin
                if (x.s.line_empty)
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_METHOD, 1'b0, hrp_pkg::ST_OK, 1'b1);
                    x.s.phase = hrp_pkg::PH_DONE;
                end
                else
                begin
                    x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_NAME, 1'b1,
                             x.s.name_good ? hrp_pkg::ST_OK : hrp_pkg::ST_BAD_NAME, 1'b0);
                    x.s = new_line(x.s);
                end
            end
            hrp_pkg::PH_VALUE:
            begin
                x = emit(x, 8'h00, 1'b0, hrp_pkg::KIND_VALUE, 1'b1, hrp_pkg::ST_OK, 1'b0);
                x.s = new_line(x.s);
            end
            hrp_pkg::PH_REQREST, hrp_pkg::PH_SKIP:
            begin
                x.s = new_line(x.s);
            end
            default:
            begin
            end
        endcase
        return x;
    endfunction

    function automatic logic is_active(input pstate_t s);
        return !(s.phase inside {hrp_pkg::PH_STOP, hrp_pkg::PH_DONE});
    endfunction

    // one full parse step for the byte on the port
    always_comb
    begin
        logic hdr;
        ctx.s   = state_reg;
        ctx.run = '0;
        hdr     = state_reg.phase inside {hrp_pkg::PH_NAME, hrp_pkg::PH_VALUE};
        if (is_active(ctx.s))
        begin
            if (ctx.s.held_flag && ctx.s.held_char == hrp_pkg::CHAR_CR
                && data_byte == hrp_pkg::CHAR_LF)
            begin
                ctx.s.held_flag = 1'b0;
                ctx.s.held_char = 8'h00;
                ctx = end_of_line(ctx);
            end
            else if (ctx.s.held_flag && ctx.s.held_char == hrp_pkg::CHAR_COLON
                     && data_byte == hrp_pkg::CHAR_SP && hdr)
            begin
                ctx.s.held_flag = 1'b0;
                ctx.s.held_char = 8'h00;
                ctx = colon_space(ctx);
            end
            else
            begin
                ctx = release_held(ctx);
                if (data_byte == hrp_pkg::CHAR_CR || (data_byte == hrp_pkg::CHAR_COLON && hdr))
                begin
                    ctx.s.held_flag = 1'b1;
                    ctx.s.held_char = data_byte;
                end
                else if (data_byte == hrp_pkg::CHAR_SP && ctx.s.phase inside
                         {hrp_pkg::PH_METHOD, hrp_pkg::PH_URL, hrp_pkg::PH_VERSION})
                begin
                    ctx = space_delim(ctx);
                end
                else
                begin
                    ctx = field_byte(ctx, data_byte);
                end
            end
            // buffer end closes the current line
            if (last_byte && is_active(ctx.s))
            begin
                ctx = release_held(ctx);
                ctx = end_of_line(ctx);
            end
        end
    end

    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;
    assign push       = accept && (ctx.run.cnt != '0);
    assign push_run   = ctx.run;
    assign state_next = accept ? ctx.s : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= hrp_pkg::PH_METHOD;
            state_reg.held_char     <= 8'h00;
            state_reg.held_flag     <= 1'b0;
            state_reg.cand          <= '1;
            state_reg.pos           <= 3'd0;
            state_reg.name_good     <= 1'b1;
            state_reg.name_nonempty <= 1'b0;
            state_reg.line_empty    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/hrp_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// hrp_queue
// short fifo of result runs between the front and back parts
// ============================================================================
module hrp_queue
#(
    parameter int DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hrp_pkg::run_t push_run,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output hrp_pkg::run_t head_run
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrp_pkg::run_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_run   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("run popped from an empty queue");

endmodule

/* design/hrp_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// hrp_back
// walks the head run and hands out its results one per cycle while out_stall is low
// ============================================================================
module hrp_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  hrp_pkg::run_t head_run,
    input  logic          out_stall,
    output logic          pop,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic [2:0]    field_kind,
    output logic          token_end,
    output logic [2:0]    status,
    output logic          headers_done,
    output logic          last_of_run
);

    logic [hrp_pkg::RES_CNT_W-1:0] idx_reg;
    logic [hrp_pkg::RES_CNT_W-1:0] idx_next;
    hrp_pkg::res_t                 cur;
    logic                          is_last;
    logic                          take;

    assign cur     = head_run.res[idx_reg];
    assign is_last = (idx_reg + hrp_pkg::RES_CNT_W'(1)) == head_run.cnt;
    assign take    = head_valid && !out_stall;
    assign pop     = take && is_last;

    assign out_valid    = head_valid;
    assign out_byte     = cur.out_byte;
    assign byte_valid   = cur.byte_valid;
    assign field_kind   = cur.field_kind;
    assign token_end    = cur.token_end;
    assign status       = cur.status;
    assign headers_done = cur.headers_done;
    assign last_of_run  = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = is_last ? '0 : idx_reg + hrp_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head_run.cnt)
        else $error("result index beyond the run length");

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == '0)
        else $error("result index left over with no run");

endmodule
